/* src/acfs_pkg.sv */
// Shared types, the letter key table and the presentation form table for the
// Arabic contextual form selector. No dependencies.
package acfs_pkg;

  localparam int LetterCount = 29;
  localparam int CodeWidth   = 16;
  localparam int RowWidth    = $clog2(LetterCount);

  typedef logic [CodeWidth-1:0] code_t;
  typedef logic [RowWidth-1:0]  row_t;

  typedef enum logic [1:0] {
    FORM_ISOLATED = 2'd0,
    FORM_INITIAL  = 2'd1,
    FORM_MEDIAL   = 2'd2,
    FORM_FINAL    = 2'd3
  } form_kind_t;

  typedef struct packed {
    logic hit;
    row_t row;
  } match_t;

  typedef struct packed {
    code_t isolated;
    code_t initial_f;
    code_t medial;
    code_t final_f;
  } forms_t;

  localparam code_t RomKey [LetterCount] = '{
    16'h0627, 16'h0628, 16'h0629, 16'h062a, 16'h062b, 16'h062c, 16'h062d,
    16'h062e, 16'h062f, 16'h0630, 16'h0631, 16'h0632, 16'h0633, 16'h0634,
    16'h0635, 16'h0636, 16'h0637, 16'h0638, 16'h0639, 16'h063a, 16'h0641,
    16'h0642, 16'h0643, 16'h0644, 16'h0645, 16'h0646, 16'h0647, 16'h0648,
    16'h064a
  };

  localparam code_t RomForm [LetterCount][4] = '{
    '{16'hfe8d, 16'h0000, 16'h0000, 16'hfe8e},
    '{16'hfe8f, 16'hfe91, 16'hfe92, 16'hfe90},
    '{16'hfe93, 16'h0000, 16'h0000, 16'hfe94},
    '{16'hfe95, 16'hfe97, 16'hfe98, 16'hfe96},
    '{16'hfe99, 16'hfe9b, 16'hfe9c, 16'hfe9a},
    '{16'hfe9d, 16'hfe9f, 16'hfea0, 16'hfe9e},
    '{16'hfea1, 16'hfea3, 16'hfea4, 16'hfea2},
    '{16'hfea5, 16'hfea7, 16'hfea8, 16'hfea6},
    '{16'hfea9, 16'h0000, 16'h0000, 16'hfeaa},
    '{16'hfeab, 16'h0000, 16'h0000, 16'hfeac},
    '{16'hfead, 16'h0000, 16'h0000, 16'hfeae},
    '{16'hfeaf, 16'h0000, 16'h0000, 16'hfeb0},
    '{16'hfeb1, 16'hfeb3, 16'hfeb4, 16'hfeb2},
    '{16'hfeb5, 16'hfeb7, 16'hfeb8, 16'hfeb6},
    '{16'hfeb9, 16'hfebb, 16'hfebc, 16'hfeba},
    '{16'hfebd, 16'hfebf, 16'hfec0, 16'hfebe},
    '{16'hfec1, 16'hfec3, 16'hfec4, 16'hfec2},
    '{16'hfec5, 16'hfec7, 16'hfec8, 16'hfec6},
    '{16'hfec9, 16'hfecb, 16'hfecc, 16'hfeca},
    '{16'hfecd, 16'hfecf, 16'hfed0, 16'hfece},
    '{16'hfed1, 16'hfed3, 16'hfed4, 16'hfed2},
    '{16'hfed5, 16'hfed7, 16'hfed8, 16'hfed6},
    '{16'hfed9, 16'hfedb, 16'hfedc, 16'hfeda},
    '{16'hfedd, 16'hfedf, 16'hfee0, 16'hfede},
    '{16'hfee1, 16'hfee3, 16'hfee4, 16'hfee2},
    '{16'hfee5, 16'hfee7, 16'hfee8, 16'hfee6},
    '{16'hfee9, 16'hfeeb, 16'hfeec, 16'hfeea},
    '{16'hfeed, 16'h0000, 16'h0000, 16'hfeee},
    '{16'hfef1, 16'hfef3, 16'hfef4, 16'hfef2}
  };

endpackage

/* src/acfs_match.sv */
// Key match of one code unit against the letter table.
// Depends on acfs_pkg.
module acfs_match (
  input  acfs_pkg::code_t  code,
  output acfs_pkg::match_t match
);

  always_comb begin
    match = '0;
    for (int i = 0; i < acfs_pkg::LetterCount; i++) begin
      if (code == acfs_pkg::RomKey[i]) begin
        match.hit = 1'b1;
        match.row = match.row | acfs_pkg::row_t'(i);
      end
    end
  end

endmodule

/* src/acfs_form_rom.sv */
// Presentation form lookup for one matched table row; all zero on a miss.
// Depends on acfs_pkg.
module acfs_form_rom (
  input  acfs_pkg::match_t match,
  output acfs_pkg::forms_t forms
);

  always_comb begin
    forms = '0;
    for (int i = 0; i < acfs_pkg::LetterCount; i++) begin
      if (match.hit && match.row == acfs_pkg::row_t'(i)) begin
        forms.isolated  = acfs_pkg::RomForm[i][acfs_pkg::FORM_ISOLATED];
        forms.initial_f = acfs_pkg::RomForm[i][acfs_pkg::FORM_INITIAL];
        forms.medial    = acfs_pkg::RomForm[i][acfs_pkg::FORM_MEDIAL];
        forms.final_f   = acfs_pkg::RomForm[i][acfs_pkg::FORM_FINAL];
      end
    end
  end

endmodule

/* src/arabic_contextual_form_select_unit.sv */
// Top level of the Arabic contextual form selector: three-stage pipeline of
// key match, form lookup and form selection. Depends on acfs_pkg,
// acfs_match and acfs_form_rom.
//
// Usage:
//   Input channel in_*: a letter with its previous and next neighbors
//   (0 for none). A transfer takes place when in_valid is high and in_stall
//   is low. Result channel out_*: the chosen presentation form and a flag
//   that the letter is in the table; a transfer takes place when out_valid
//   is high and out_stall is low.
//   An accepted item passes the match, lookup and select register stages, in
//   that order, before it is offered with out_valid.
//   Throughput: one item per cycle while out_stall stays low.
//   Stall: a stage advances when the stage after it is empty or moving, so
//   bubbles close up while the output waits; in_stall rises only once all
//   three stages hold items and out_stall is high. Nothing is lost or
//   repeated.
//   Reset: synchronous on rst_n low; all stages are emptied.
module arabic_contextual_form_select_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  acfs_pkg::code_t in_this_letter,
  input  acfs_pkg::code_t in_prev_letter,
  input  acfs_pkg::code_t in_next_letter,
  output logic            out_valid,
  input  logic            out_stall,
  output acfs_pkg::code_t out_shaped_letter,
  output logic            out_letter_known
);

  logic ld1, ld2, ld3;
  logic v1_r, v2_r, v3_r;

  acfs_pkg::match_t this_m, prev_m, next_m;
  acfs_pkg::match_t this_m_r, prev_m_r, next_m_r;

  acfs_pkg::forms_t this_f, prev_f;
  acfs_pkg::forms_t forms_r;
  logic             known_r, prev_hit_r, next_hit_r, prev_joins_r;

  acfs_pkg::code_t  pick, shaped_nxt;
  acfs_pkg::code_t  shaped_r;
  logic             known3_r;

  assign ld3      = !v3_r || !out_stall;
  assign ld2      = !v2_r || ld3;
  assign ld1      = !v1_r || ld2;
  assign in_stall = !ld1;

  acfs_match u_match_this (.code(in_this_letter), .match(this_m));
  acfs_match u_match_prev (.code(in_prev_letter), .match(prev_m));
  acfs_match u_match_next (.code(in_next_letter), .match(next_m));

  acfs_form_rom u_rom_this (.match(this_m_r), .forms(this_f));
  acfs_form_rom u_rom_prev (.match(prev_m_r), .forms(prev_f));

  always_comb begin
    if (next_hit_r) begin
      pick = prev_joins_r ? forms_r.medial : forms_r.initial_f;
    end else if (prev_hit_r) begin
      pick = forms_r.final_f;
    end else begin
      pick = '0;
    end
    shaped_nxt = (pick != '0) ? pick : forms_r.isolated;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld1) v1_r <= in_valid;
      if (ld2) v2_r <= v1_r;
      if (ld3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      this_m_r <= this_m;
      prev_m_r <= prev_m;
      next_m_r <= next_m;
    end
    if (ld2) begin
      forms_r      <= this_f;
      known_r      <= this_m_r.hit;
      prev_hit_r   <= prev_m_r.hit;
      next_hit_r   <= next_m_r.hit;
      prev_joins_r <= prev_m_r.hit && (prev_f.initial_f != '0);
    end
    if (ld3) begin
      shaped_r <= shaped_nxt;
      known3_r <= known_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_shaped_letter = shaped_r;
  assign out_letter_known  = known3_r;

  a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_letter_known |-> out_shaped_letter == '0)
    else $error("unknown letter gave a nonzero form");

  a_known_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_letter_known |-> out_shaped_letter != '0)
    else $error("known letter gave a zero form");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted item missing from first stage");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_stall)
    else $error("input stalled with room in the pipeline");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !v1_r && !v2_r)
    else $error("pipeline not empty after reset");

endmodule

/* tb/sv/acfs_shaping_checker.sv */
`timescale 1ns / 100ps
// Result checker for the Arabic contextual form selector: predicts the shaped
// letter of every input transfer and compares result transfers in order.
// Depends on acfs_pkg for the code type and the form kinds.
module acfs_shaping_checker (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  logic            in_stall,
  input  acfs_pkg::code_t in_this_letter,
  input  acfs_pkg::code_t in_prev_letter,
  input  acfs_pkg::code_t in_next_letter,
  input  logic            out_valid,
  input  logic            out_stall,
  input  acfs_pkg::code_t out_shaped_letter,
  input  logic            out_letter_known,
  input  logic            end_check,
  output int              fail_count,
  output int              pending_count
);

  typedef struct packed {
    acfs_pkg::code_t shaped;
    logic            known;
  } shape_t;

  localparam int NumLetters = 29;

  localparam acfs_pkg::code_t LetterCode [NumLetters] = '{
    16'h0627, 16'h0628, 16'h0629, 16'h062a, 16'h062b, 16'h062c, 16'h062d,
    16'h062e, 16'h062f, 16'h0630, 16'h0631, 16'h0632, 16'h0633, 16'h0634,
    16'h0635, 16'h0636, 16'h0637, 16'h0638, 16'h0639, 16'h063a, 16'h0641,
    16'h0642, 16'h0643, 16'h0644, 16'h0645, 16'h0646, 16'h0647, 16'h0648,
    16'h064a
  };

  // Final form follows the isolated one; dual-joining letters add initial
  // and medial right after it.
  localparam acfs_pkg::code_t IsolatedForm [NumLetters] = '{
    16'hfe8d, 16'hfe8f, 16'hfe93, 16'hfe95, 16'hfe99, 16'hfe9d, 16'hfea1,
    16'hfea5, 16'hfea9, 16'hfeab, 16'hfead, 16'hfeaf, 16'hfeb1, 16'hfeb5,
    16'hfeb9, 16'hfebd, 16'hfec1, 16'hfec5, 16'hfec9, 16'hfecd, 16'hfed1,
    16'hfed5, 16'hfed9, 16'hfedd, 16'hfee1, 16'hfee5, 16'hfee9, 16'hfeed,
    16'hfef1
  };

  localparam bit JoinsBoth [NumLetters] = '{
    1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
    1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1
  };

  shape_t expected_forms [$];
  int     errors = 0;
  bit     end_seen = 1'b0;

  function automatic int letter_row(acfs_pkg::code_t c);
    for (int i = 0; i < NumLetters; i++) begin
      if (LetterCode[i] == c) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic acfs_pkg::code_t form_of(int row, acfs_pkg::form_kind_t kind);
    case (kind)
      acfs_pkg::FORM_ISOLATED: return IsolatedForm[row];
      acfs_pkg::FORM_FINAL:    return IsolatedForm[row] + 16'd1;
      acfs_pkg::FORM_INITIAL:  return JoinsBoth[row] ? IsolatedForm[row] + 16'd2 : '0;
      default:                 return JoinsBoth[row] ? IsolatedForm[row] + 16'd3 : '0;
    endcase
  endfunction

  function automatic shape_t predict_shape(acfs_pkg::code_t this_c,
                                           acfs_pkg::code_t prev_c,
                                           acfs_pkg::code_t next_c);
    int              row;
    int              prow;
    int              nrow;
    acfs_pkg::code_t pick;
    shape_t          s;
    row  = letter_row(this_c);
    prow = letter_row(prev_c);
    nrow = letter_row(next_c);
    if (row < 0) begin
      s.shaped = '0;
      s.known  = 1'b0;
      return s;
    end
    pick = '0;
    if (nrow >= 0) begin
      if (prow >= 0 && form_of(prow, acfs_pkg::FORM_INITIAL) != '0) begin
        pick = form_of(row, acfs_pkg::FORM_MEDIAL);
      end else begin
        pick = form_of(row, acfs_pkg::FORM_INITIAL);
      end
    end else if (prow >= 0) begin
      pick = form_of(row, acfs_pkg::FORM_FINAL);
    end
    s.shaped = (pick != '0) ? pick : form_of(row, acfs_pkg::FORM_ISOLATED);
    s.known  = 1'b1;
    return s;
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  always @(posedge clk) begin : watch
    shape_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_forms.push_back(predict_shape(in_this_letter, in_prev_letter,
                                               in_next_letter));
      end
      if (out_valid && !out_stall) begin
        if (expected_forms.size() == 0) begin
          report_mismatch($sformatf("result %h/%b with nothing expected",
                                    out_shaped_letter, out_letter_known));
        end else begin
          want = expected_forms.pop_front();
          if (out_shaped_letter !== want.shaped) begin
            report_mismatch($sformatf("shaped_letter %h, expected %h",
                                      out_shaped_letter, want.shaped));
          end
          if (out_letter_known !== want.known) begin
            report_mismatch($sformatf("letter_known %b, expected %b",
                                      out_letter_known, want.known));
          end
        end
      end
      if (end_check && !end_seen) begin
        end_seen = 1'b1;
        if (expected_forms.size() != 0) begin
          report_mismatch($sformatf("%0d results never arrived", expected_forms.size()));
        end
      end
    end
    pending_count <= expected_forms.size();
    fail_count    <= errors;
  end

endmodule

/* tb/sv/tb_arabic_contextual_form_select_unit.sv */
`timescale 1ns / 100ps
// Testbench top for the Arabic contextual form selector: drives letters with
// random idling and stalls and gives the verdict. Depends on acfs_pkg, the
// block and acfs_shaping_checker.
module tb_arabic_contextual_form_select_unit;

  localparam int HoldOffCycles = 300;
  localparam int IdleLimit     = 2000;
  localparam int PhaseItems    = 300;
  localparam int DrainCycles   = 8;

  logic            clk              = 1'b0;
  logic            rst_n            = 1'b0;
  logic            in_valid         = 1'b0;
  logic            in_stall;
  acfs_pkg::code_t in_this_letter   = '0;
  acfs_pkg::code_t in_prev_letter   = '0;
  acfs_pkg::code_t in_next_letter   = '0;
  logic            out_valid;
  logic            out_stall        = 1'b0;
  acfs_pkg::code_t out_shaped_letter;
  logic            out_letter_known;
  logic            end_check        = 1'b0;
  logic            hold_start       = 1'b0;
  int              stall_pct        = 0;
  int              send_idle_pct    = 0;
  int              hold_left        = 0;
  int              quiet_cycles     = 0;
  int              fail_count;
  int              pending_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  arabic_contextual_form_select_unit u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_this_letter    (in_this_letter),
    .in_prev_letter    (in_prev_letter),
    .in_next_letter    (in_next_letter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_shaped_letter (out_shaped_letter),
    .out_letter_known  (out_letter_known)
  );

  acfs_shaping_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_this_letter    (in_this_letter),
    .in_prev_letter    (in_prev_letter),
    .in_next_letter    (in_next_letter),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_shaped_letter (out_shaped_letter),
    .out_letter_known  (out_letter_known),
    .end_check         (end_check),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // hold off the result channel for a long stretch on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_start) begin
      hold_left <= HoldOffCycles;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_letter(acfs_pkg::code_t this_c, acfs_pkg::code_t prev_c,
                             acfs_pkg::code_t next_c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_this_letter <= this_c;
    in_prev_letter <= prev_c;
    in_next_letter <= next_c;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
  endtask

  // mostly letters around the Arabic block, gaps included
  function automatic acfs_pkg::code_t pick_code(int zero_pct, int wild_pct);
    int r;
    r = $urandom_range(99);
    if (r < zero_pct) begin
      return '0;
    end
    if (r < zero_pct + wild_pct) begin
      return acfs_pkg::code_t'($urandom_range(16'hffff));
    end
    return acfs_pkg::code_t'($urandom_range(16'h064a, 16'h0627));
  endfunction

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic run_random(int count, int idle, int stall);
    send_idle_pct = idle;
    stall_pct    <= stall;
    repeat (count) begin
      send_letter(pick_code(2, 18), pick_code(20, 20), pick_code(20, 20));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_letter(16'h0628, 16'h0000, 16'h0000);
    send_letter(16'h0628, 16'h0628, 16'h0000);
    send_letter(16'h0628, 16'h0000, 16'h0628);
    send_letter(16'h0628, 16'h062c, 16'h0644);
    send_letter(16'h0628, 16'h0627, 16'h0644);
    send_letter(16'h0627, 16'h0628, 16'h0628);
    send_letter(16'h0627, 16'h0000, 16'h0628);
    send_letter(16'h0627, 16'h0644, 16'h0000);
    send_letter(16'h064a, 16'h0645, 16'h0645);
    send_letter(16'h064a, 16'h1234, 16'hffff);
    send_letter(16'h0000, 16'h0628, 16'h0628);
    send_letter(16'hffff, 16'hffff, 16'hffff);
    send_letter(16'h0626, 16'h0628, 16'h0628);
    send_letter(16'h064b, 16'h0000, 16'h0000);
    send_letter(16'h0649, 16'h0628, 16'h0628);
    send_letter(16'h0640, 16'h0000, 16'h0000);
    send_letter(16'h0629, 16'h0628, 16'h0628);
    send_letter(16'h0648, 16'h0648, 16'h0000);
    send_letter(16'h0644, 16'h0000, 16'h0649);
    send_letter(16'h0644, 16'h0649, 16'h0627);
    send_letter(16'h0633, 16'hffff, 16'h0000);
    send_letter(16'h0633, 16'h0648, 16'h0633);
    wait_drained();

    // fill the pipeline against a held-off receiver
    hold_start <= 1'b1;
    @(posedge clk);
    hold_start <= 1'b0;
    repeat (40) begin
      send_letter(pick_code(2, 18), pick_code(20, 20), pick_code(20, 20));
    end
    wait_drained();

    run_random(PhaseItems, 0, 0);
    run_random(PhaseItems, 45, 0);
    run_random(PhaseItems, 0, 45);
    wait_drained();
    run_random(PhaseItems, 24, 24);

    wait_drained();
    repeat (DrainCycles) @(posedge clk);
    end_check <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
